// ===== design/htd_pkg.sv =====
// Package for the table-driven Huffman decoder.
// Holds the request and result types, the node entry type and the shared constants.
// No dependencies.
`timescale 1ns / 1ps

package htd_pkg;

  localparam int HtdMaxNodes = 255;

  localparam logic [7:0] HtdLeafMark = 8'hFF;
  localparam logic [7:0] HtdEndChar  = 8'h7C;

  localparam logic HtdOpLoad   = 1'b0;
  localparam logic HtdOpDecode = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] node_index;
    logic [7:0] node_symbol;
    logic [7:0] node_left;
    logic [7:0] node_right;
    logic [7:0] code_byte;
  } htd_in_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_mark;
    logic       last;
  } htd_out_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic [7:0] left;
    logic [7:0] right;
  } htd_entry_t;

  typedef struct packed {
    logic     valid;
    htd_out_t data;
  } htd_push_t;

  localparam int HtdEntryW = $bits(htd_entry_t);

endpackage

// ===== design/htd_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// Read data changes only on a read enable. No dependencies.
`timescale 1ns / 1ps

module htd_ram #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/htd_walk.sv =====
// Tree walker for the Huffman decoder: table loads, one table read per code bit,
// pending-result holding for the last flag. Depends on htd_pkg and an external htd_ram.
`timescale 1ns / 1ps

module htd_walk #(
  parameter int MaxNodes = htd_pkg::HtdMaxNodes
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  htd_pkg::htd_in_t            in_req_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  root_i,
  output logic                        ram_we_o,
  output logic [$clog2(MaxNodes)-1:0] ram_waddr_o,
  output logic [htd_pkg::HtdEntryW-1:0] ram_wdata_o,
  output logic                        ram_re_o,
  output logic [$clog2(MaxNodes)-1:0] ram_raddr_o,
  input  logic [htd_pkg::HtdEntryW-1:0] ram_rdata_i,
  output htd_pkg::htd_push_t          push_o,
  input  logic                        out_free_i
);

  import htd_pkg::*;

  localparam int AddrW = $clog2(MaxNodes);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRoot  = 3'd1;
  localparam logic [2:0] StFetch = 3'd2;
  localparam logic [2:0] StWalk  = 3'd3;
  localparam logic [2:0] StFlush = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [7:0]  byte_q, byte_d;
  logic [2:0]  bit_cnt_q, bit_cnt_d;
  htd_entry_t  root_ent_q, root_ent_d;
  logic [7:0]  child_q, child_d;
  logic        oor_q, oor_d;
  logic [7:0]  walk_q, walk_d;
  logic        at_root_q, at_root_d;
  logic        pend_valid_q, pend_valid_d;
  logic [7:0]  pend_sym_q, pend_sym_d;
  logic        pend_end_q, pend_end_d;

  htd_entry_t  rd_ent;
  htd_entry_t  next_ent;
  htd_entry_t  here;
  logic        step;
  logic        leaf;
  logic        term;
  logic        go;
  logic [7:0]  child;
  logic        child_oor;
  logic        accept;

  assign rd_ent     = htd_entry_t'(ram_rdata_i);
  assign next_ent   = oor_q ? htd_entry_t'('0) : rd_ent;
  assign leaf       = (next_ent.left == HtdLeafMark) && (next_ent.right == HtdLeafMark);
  assign term       = (next_ent.symbol == HtdEndChar);
  assign go         = !(leaf && pend_valid_q) || out_free_i;
  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && !in_stall_o;

  assign ram_we_o    = accept && (in_req_i.op == HtdOpLoad) &&
                       (32'(in_req_i.node_index) < MaxNodes);
  assign ram_waddr_o = in_req_i.node_index[AddrW-1:0];
  assign ram_wdata_o = {in_req_i.node_symbol, in_req_i.node_left, in_req_i.node_right};

  always_comb begin
    state_d      = state_q;
    byte_d       = byte_q;
    bit_cnt_d    = bit_cnt_q;
    root_ent_d   = root_ent_q;
    child_d      = child_q;
    oor_d        = oor_q;
    walk_d       = walk_q;
    at_root_d    = at_root_q;
    pend_valid_d = pend_valid_q;
    pend_sym_d   = pend_sym_q;
    pend_end_d   = pend_end_q;
    ram_re_o     = 1'b0;
    ram_raddr_o  = root_i[AddrW-1:0];
    push_o       = '0;
    here         = rd_ent;
    step         = 1'b0;

    case (state_q)
      StIdle: begin
        if (accept && (in_req_i.op == HtdOpDecode)) begin
          ram_re_o     = 1'b1;
          ram_raddr_o  = root_i[AddrW-1:0];
          byte_d       = in_req_i.code_byte;
          bit_cnt_d    = '0;
          pend_valid_d = 1'b0;
          oor_d        = 1'b0;
          state_d      = StRoot;
        end
      end
      StRoot: begin
        root_ent_d = rd_ent;
        if (at_root_q) begin
          here    = rd_ent;
          step    = 1'b1;
          state_d = StWalk;
        end else begin
          oor_d       = (32'(walk_q) >= MaxNodes);
          ram_re_o    = (32'(walk_q) < MaxNodes);
          ram_raddr_o = walk_q[AddrW-1:0];
          state_d     = StFetch;
        end
      end
      StFetch: begin
        here    = next_ent;
        step    = 1'b1;
        state_d = StWalk;
      end
      StWalk: begin
        if (go) begin
          bit_cnt_d = bit_cnt_q + 3'd1;
          if (leaf) begin
            if (pend_valid_q) begin
              push_o.valid         = 1'b1;
              push_o.data.symbol   = pend_sym_q;
              push_o.data.end_mark = pend_end_q;
              push_o.data.last     = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_sym_d   = term ? 8'd0 : next_ent.symbol;
            pend_end_d   = term;
            if (term || (bit_cnt_q == 3'd7)) begin
              walk_d    = root_i;
              at_root_d = 1'b1;
              state_d   = StFlush;
            end else begin
              here = root_ent_q;
              step = 1'b1;
            end
          end else if (bit_cnt_q == 3'd7) begin
            walk_d    = child_q;
            at_root_d = (child_q == root_i);
            state_d   = StFlush;
          end else begin
            here = next_ent;
            step = 1'b1;
          end
        end
      end
      StFlush: begin
        if (!pend_valid_q) begin
          state_d = StIdle;
        end else if (out_free_i) begin
          push_o.valid         = 1'b1;
          push_o.data.symbol   = pend_sym_q;
          push_o.data.end_mark = pend_end_q;
          push_o.data.last     = 1'b1;
          pend_valid_d         = 1'b0;
          state_d              = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    child     = byte_q[7] ? here.right : here.left;
    child_oor = (32'(child) >= MaxNodes);

    if (step) begin
      ram_re_o    = !child_oor;
      ram_raddr_o = child[AddrW-1:0];
      child_d     = child;
      oor_d       = child_oor;
      byte_d      = {byte_q[6:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      walk_q       <= '0;
      at_root_q    <= 1'b1;
      pend_valid_q <= 1'b0;
      bit_cnt_q    <= '0;
    end else begin
      state_q      <= state_d;
      walk_q       <= walk_d;
      at_root_q    <= at_root_d;
      pend_valid_q <= pend_valid_d;
      bit_cnt_q    <= bit_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    root_ent_q <= root_ent_d;
    child_q    <= child_d;
    oor_q      <= oor_d;
    pend_sym_q <= pend_sym_d;
    pend_end_q <= pend_end_d;
  end

endmodule

// ===== design/huffman_table_decoder_core.sv =====
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_stall_o    htd_in_t: node load or code byte
// out      output     out_valid_o / out_stall_i  htd_out_t: symbol, end mark, last
// cfg      input      cfg_valid_i / cfg_ready_o  tree size register
//
// A load request is written to the table when accepted and leaves the input free. A code
// byte request stalls the input until its walk ends: the accepting cycle reads the root,
// StRoot takes the root entry, StFetch follows when the walk resumes inside the tree,
// StWalk steps the code bits and StFlush hands over the final result. A terminator leaf
// ends the byte early. Reset puts the walk at the root and the tree size at one; the node
// table is undefined until loaded. Results leave through an output register, so the walker
// keeps going while one result waits. Depends on htd_pkg, htd_walk and htd_ram.
`timescale 1ns / 1ps

module huffman_table_decoder_core #(
  parameter int MaxNodes = htd_pkg::HtdMaxNodes
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  htd_pkg::htd_in_t  in_req_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  output htd_pkg::htd_out_t out_req_o,
  input  logic              out_stall_i,
  input  logic              cfg_valid_i,
  input  logic [7:0]        cfg_data_i,
  output logic              cfg_ready_o
);

  import htd_pkg::*;

  localparam int AddrW = $clog2(MaxNodes);

  logic [7:0]           count_q;
  logic [7:0]           count_clamped;
  logic [7:0]           root;
  logic                 out_valid_q;
  htd_out_t             out_q;
  logic                 out_free;
  htd_push_t            push;
  logic                 ram_we;
  logic [AddrW-1:0]     ram_waddr;
  logic [HtdEntryW-1:0] ram_wdata;
  logic                 ram_re;
  logic [AddrW-1:0]     ram_raddr;
  logic [HtdEntryW-1:0] ram_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 8'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      count_q <= cfg_data_i;
    end
  end

  always_comb begin
    count_clamped = count_q;
    if (count_q == 8'd0) begin
      count_clamped = 8'd1;
    end else if (32'(count_q) > MaxNodes) begin
      count_clamped = 8'(MaxNodes);
    end
    root = count_clamped - 8'd1;
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push.valid) begin
      out_q <= push.data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  htd_walk #(
    .MaxNodes (MaxNodes)
  ) u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_req_i    (in_req_i),
    .in_stall_o  (in_stall_o),
    .root_i      (root),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .push_o      (push),
    .out_free_i  (out_free)
  );

  htd_ram #(
    .Width (HtdEntryW),
    .Depth (MaxNodes)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule
